@@ rtl/partial_discharge_cavity_model_assert.svh @@
// Assertion macros shared by the cavity model RTL.
`ifndef PARTIAL_DISCHARGE_CAVITY_MODEL_ASSERT_SVH
`define PARTIAL_DISCHARGE_CAVITY_MODEL_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PDCM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pdcm assertion failed");
// next-cycle implication
`define PDCM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pdcm assertion failed");
`else
`define PDCM_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define PDCM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/pdcm_pkg.sv @@
`default_nettype none
package pdcm_pkg;

   localparam int HALF_PERIOD_STEPS_DEFAULT = 200;

   localparam int SAMPLE_W   = 18;
   localparam int CAVITY_W   = 19;
   localparam int TICK_W     = 20;
   localparam int THRESH_W   = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_INCEPTION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESIDUAL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET    = 2'd2;

   localparam logic [THRESH_W-1:0] INCEPTION_RESET = 17'd39322;
   localparam logic [THRESH_W-1:0] RESIDUAL_RESET  = 17'd19661;
   localparam logic [TICK_W-1:0]   TICK_MAX        = '1;

   typedef struct packed {
      logic [THRESH_W-1:0]        uz;
      logic [THRESH_W-1:0]        up;
      logic signed [SAMPLE_W-1:0] u0;
   } cfg_type;

   // one classified sample, front to back
   typedef struct packed {
      logic                       start;
      logic                       negwin;
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [CAVITY_W-1:0] delta;
   } cmd_type;

   typedef struct packed {
      logic discharged;
      logic polarity;
      logic signed [CAVITY_W-1:0] cavity;
      logic [TICK_W-1:0] interval;
      logic interval_valid;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/partial_discharge_cavity_model.sv @@
// Path: an accepted sample goes through the queue into the back unit's output
// register, which drives rsp_tvalid. Throughput: one sample per clock unless
// rsp_tready stalls the output; the back unit's cavity add-compare-saturate loop
// is combinational on cavity_ff, and a 2-entry queue decouples intake from output.
// Reset (synchronous, active high): clears history, phase, queue and output valid,
// and restores the threshold/residual/offset registers to their defaults.
`default_nettype none
module partial_discharge_cavity_model #(
   parameter int HALF_PERIOD_STEPS = pdcm_pkg::HALF_PERIOD_STEPS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [23:0]                            req_tdata,  // [17:0] applied_sample
   input  wire logic                                   req_tuser,  // [0] restart
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // [0] discharged, [1] polarity, [20:2] cavity_voltage, [40:21] interval_ticks,
   // [41] interval_valid
   output logic [47:0]                                 rsp_tdata,
   input  wire logic                                   csr_we,
   input  wire logic [pdcm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [pdcm_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   pdcm_pkg::cfg_type cfg_ff;
   pdcm_pkg::cmd_type push_cmd, pop_cmd;
   pdcm_pkg::rsp_type rsp;
   logic push_valid, push_ready, pop_valid, pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.uz <= pdcm_pkg::INCEPTION_RESET;
         cfg_ff.up <= pdcm_pkg::RESIDUAL_RESET;
         cfg_ff.u0 <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            pdcm_pkg::CSR_INCEPTION: cfg_ff.uz <= csr_wdata[pdcm_pkg::THRESH_W-1:0];
            pdcm_pkg::CSR_RESIDUAL:  cfg_ff.up <= csr_wdata[pdcm_pkg::THRESH_W-1:0];
            pdcm_pkg::CSR_OFFSET:    cfg_ff.u0 <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   pdcm_front #(
      .HALF_PERIOD_STEPS(HALF_PERIOD_STEPS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_sample  ($signed(req_tdata[pdcm_pkg::SAMPLE_W-1:0])),
      .in_restart (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   pdcm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   pdcm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (rsp)
   );

   assign rsp_tdata = {6'b0, rsp.interval_valid, rsp.interval, rsp.cavity,
                       rsp.polarity, rsp.discharged};

endmodule
`default_nettype wire

@@ rtl/pdcm_front.sv @@
`default_nettype none
module pdcm_front #(
   parameter int HALF_PERIOD_STEPS = pdcm_pkg::HALF_PERIOD_STEPS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 in_valid,
   output logic                                      in_ready,
   input  wire logic signed [pdcm_pkg::SAMPLE_W-1:0] in_sample,
   input  wire logic                                 in_restart,
   output logic                                      push_valid,
   input  wire logic                                 push_ready,
   output pdcm_pkg::cmd_type                         push_cmd
);

   localparam int PERIOD  = 2 * HALF_PERIOD_STEPS;
   localparam int PHASE_W = $clog2(PERIOD);
   localparam int HALF    = HALF_PERIOD_STEPS / 2;
   localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PERIOD - 1);
   localparam logic [PHASE_W-1:0] WIN_LO     = PHASE_W'(HALF);
   localparam logic [PHASE_W-1:0] WIN_HI     = PHASE_W'(HALF * 3);

   logic signed [pdcm_pkg::SAMPLE_W-1:0] prev_ff, prev_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic started_ff, started_in;
   logic accept, start;

   assign in_ready   = push_ready;
   assign push_valid = in_valid;
   assign accept     = in_valid && push_ready;
   assign start      = in_restart || !started_ff;

   always_comb begin
      if (start) begin
         phase_in = '0;
      end else if (phase_ff == PHASE_LAST) begin
         phase_in = '0;
      end else begin
         phase_in = phase_ff + PHASE_W'(1);
      end
      prev_in    = in_sample;
      started_in = 1'b1;
   end

   always_comb begin
      push_cmd.start  = start;
      push_cmd.negwin = (phase_in > WIN_LO) && (phase_in <= WIN_HI);
      push_cmd.sample = in_sample;
      push_cmd.delta  = pdcm_pkg::CAVITY_W'(in_sample) - pdcm_pkg::CAVITY_W'(prev_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= '0;
         phase_ff   <= '0;
         started_ff <= 1'b0;
      end else if (accept) begin
         prev_ff    <= prev_in;
         phase_ff   <= phase_in;
         started_ff <= started_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/pdcm_queue.sv @@
`default_nettype none
`include "partial_discharge_cavity_model_assert.svh"
module pdcm_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire pdcm_pkg::cmd_type push_cmd,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output pdcm_pkg::cmd_type      pop_cmd
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   pdcm_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   `PDCM_ASSERT_NEXT(a_fill_tracks, clock, reset, push && !pop, count_ff == $past(count_ff) + CNT_W'(1))
   `PDCM_ASSERT_NEXT(a_drain_tracks, clock, reset, pop && !push, count_ff == $past(count_ff) - CNT_W'(1))
   `PDCM_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))

endmodule
`default_nettype wire

@@ rtl/pdcm_back.sv @@
`default_nettype none
`include "partial_discharge_cavity_model_assert.svh"
module pdcm_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pdcm_pkg::cfg_type cfg,
   input  wire logic              pop_valid,
   output logic                   pop_ready,
   input  wire pdcm_pkg::cmd_type pop_cmd,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output pdcm_pkg::rsp_type      out_rsp
);

   localparam int W = pdcm_pkg::CAVITY_W + 2;
   localparam logic signed [W-1:0] CAV_MAX = W'(262143);
   localparam logic signed [W-1:0] CAV_MIN = -W'(262144);

   logic signed [pdcm_pkg::CAVITY_W-1:0] cavity_ff, cavity_in, start_sum, sat_val;
   logic [pdcm_pkg::TICK_W-1:0] ticks_ff, ticks_in, ticks_inc;
   logic had_ff, had_in;
   logic out_valid_ff;
   pdcm_pkg::rsp_type rsp_ff, rsp_in;
   logic signed [W-1:0] cand, uz_w, up_w, step, adj, next_val;
   logic neg_hit, pos_hit, fire, pop;

   assign pop_ready = !out_valid_ff || out_ready;
   assign pop       = pop_valid && pop_ready;
   assign out_valid = out_valid_ff;
   assign out_rsp   = rsp_ff;

   always_comb begin
      start_sum = pdcm_pkg::CAVITY_W'(cfg.u0) + pdcm_pkg::CAVITY_W'(pop_cmd.sample);
      cand      = W'(cavity_ff) + W'(pop_cmd.delta);
      uz_w      = $signed(W'(cfg.uz));
      up_w      = $signed(W'(cfg.up));
      step      = uz_w - up_w;
      neg_hit   = (cand <= -uz_w);
      pos_hit   = (cand >= uz_w);
      fire      = pop_cmd.negwin ? neg_hit : pos_hit;
      adj       = pop_cmd.negwin ? (cand + step) : (cand - step);
      next_val  = fire ? adj : cand;
      priority if (next_val > CAV_MAX) begin
         sat_val = CAV_MAX[pdcm_pkg::CAVITY_W-1:0];
      end else if (next_val < CAV_MIN) begin
         sat_val = CAV_MIN[pdcm_pkg::CAVITY_W-1:0];
      end else begin
         sat_val = next_val[pdcm_pkg::CAVITY_W-1:0];
      end
      ticks_inc = (ticks_ff == pdcm_pkg::TICK_MAX) ? ticks_ff
                                                   : ticks_ff + pdcm_pkg::TICK_W'(1);

      rsp_in = '0;
      if (pop_cmd.start) begin
         cavity_in     = start_sum;
         ticks_in      = '0;
         had_in        = 1'b0;
         rsp_in.cavity = start_sum;
      end else begin
         cavity_in         = sat_val;
         ticks_in          = fire ? '0 : ticks_inc;
         had_in            = had_ff || fire;
         rsp_in.discharged = fire;
         rsp_in.polarity   = fire && pop_cmd.negwin;
         rsp_in.cavity     = sat_val;
         if (fire && had_ff) begin
            rsp_in.interval_valid = 1'b1;
            rsp_in.interval       = ticks_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cavity_ff    <= '0;
         ticks_ff     <= '0;
         had_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            cavity_ff <= cavity_in;
            ticks_ff  <= ticks_in;
            had_ff    <= had_in;
         end
         if (pop_ready) begin
            out_valid_ff <= pop_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   `PDCM_ASSERT_NEXT(a_start_no_fire, clock, reset, pop && pop_cmd.start, !rsp_ff.discharged && !had_ff)
   `PDCM_ASSERT_NOW(a_quiet_fields, clock, reset, out_valid_ff && !rsp_ff.discharged, !rsp_ff.polarity && !rsp_ff.interval_valid && (rsp_ff.interval == '0))
   `PDCM_ASSERT_NEXT(a_fire_clears_ticks, clock, reset, pop && !pop_cmd.start && fire, (ticks_ff == '0) && had_ff)

endmodule
`default_nettype wire

@@ verif/partial_discharge_cavity_model_tb.sv @@
`default_nettype none
module partial_discharge_cavity_model_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pdcm_pkg::*;

   localparam int HALF = HALF_PERIOD_STEPS_DEFAULT;
   localparam int PERIOD = 2 * HALF;
   localparam longint CAV_HI = 262143;
   localparam longint CAV_LO = -262144;
   localparam int SAMPLE_HI = 131071;
   localparam int SAMPLE_LO = -131072;

   typedef struct {
      logic signed [SAMPLE_W-1:0] value;
      logic                       restart;
   } voltage_sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;        // [17:0] applied_sample
   logic req_tuser = 1'b0;             // [0] restart
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // [0] discharged, [1] polarity, [20:2] cavity_voltage, [40:21] interval_ticks,
   // [41] interval_valid
   logic [47:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_INCEPTION;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   partial_discharge_cavity_model uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor copy of registers and cavity state
   logic [THRESH_W-1:0] uz_cfg = INCEPTION_RESET;
   logic [THRESH_W-1:0] up_cfg = RESIDUAL_RESET;
   logic signed [SAMPLE_W-1:0] u0_cfg = '0;
   logic signed [SAMPLE_W-1:0] last_sample = '0;
   logic signed [CAVITY_W-1:0] cavity_now = '0;
   int phase_now = 0;
   bit running = 1'b0;
   logic [TICK_W-1:0] ticks_now = '0;
   bit fired_before = 1'b0;

   voltage_sample_type pending_q[$];
   rsp_type cavity_result_q[$];
   voltage_sample_type on_bus;

   int idle_odds = 4;
   int send_gap = 0;
   int take_gap = 0;
   logic rsp_blocked = 1'b0;

   int samples_taken = 0;
   int results_seen = 0;
   int error_count = 0;
   int pos_discharges = 0;
   int neg_discharges = 0;
   int interval_hits = 0;
   int saturated_hits = 0;
   int settings_used = 0;
   logic [TICK_W-1:0] longest_interval = '0;

   function automatic logic signed [CAVITY_W-1:0] clamp_cavity(longint v);
      if (v > CAV_HI)
         return CAVITY_W'(CAV_HI);
      if (v < CAV_LO)
         return CAVITY_W'(CAV_LO);
      return v[CAVITY_W-1:0];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] clip_sample(longint v);
      if (v > SAMPLE_HI)
         return SAMPLE_W'(SAMPLE_HI);
      if (v < SAMPLE_LO)
         return SAMPLE_W'(SAMPLE_LO);
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic void advance_cavity(voltage_sample_type s);
      rsp_type want;
      longint cand;
      longint uz;
      longint step;
      bit negwin;
      want = '0;
      if (s.restart || !running) begin
         phase_now = 0;
         cavity_now = clamp_cavity(longint'(u0_cfg) + longint'(s.value));
         running = 1'b1;
         ticks_now = '0;
         fired_before = 1'b0;
      end else begin
         uz = longint'(uz_cfg);
         step = uz - longint'(up_cfg);
         cand = longint'(cavity_now) + longint'(s.value) - longint'(last_sample);
         phase_now++;
         if (phase_now >= PERIOD)
            phase_now = 0;
         if (ticks_now != TICK_MAX)
            ticks_now++;
         negwin = (HALF / 2 < phase_now) && (phase_now <= (HALF / 2) * 3);
         // only one polarity is armed at any point in the period
         if (negwin && cand <= -uz) begin
            cand += step;
            want.discharged = 1'b1;
            want.polarity = 1'b1;
         end else if (!negwin && cand >= uz) begin
            cand -= step;
            want.discharged = 1'b1;
         end
         cavity_now = clamp_cavity(cand);
         if (want.discharged) begin
            if (fired_before) begin
               want.interval_valid = 1'b1;
               want.interval = ticks_now;
            end
            fired_before = 1'b1;
            ticks_now = '0;
         end
      end
      last_sample = s.value;
      want.cavity = cavity_now;
      cavity_result_q.insert(cavity_result_q.size(), want);
   endfunction

   function automatic void match_field(string name, logic [19:0] want, logic [19:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endfunction

   function automatic void check_cavity_result(logic [47:0] bus);
      rsp_type want;
      results_seen++;
      if (cavity_result_q.size() == 0) begin
         error_count++;
         $display("%0t: result with nothing expected, got %h", $time, bus);
         return;
      end
      want = cavity_result_q.pop_front();
      match_field("discharged", 20'(want.discharged), 20'(bus[0]));
      match_field("polarity", 20'(want.polarity), 20'(bus[1]));
      match_field("cavity_voltage", {1'b0, want.cavity}, {1'b0, bus[20:2]});
      match_field("interval_ticks", want.interval, bus[40:21]);
      match_field("interval_valid", 20'(want.interval_valid), 20'(bus[41]));
      if (want.discharged) begin
         if (want.polarity)
            neg_discharges++;
         else
            pos_discharges++;
      end
      if (want.interval_valid) begin
         interval_hits++;
         if (want.interval > longest_interval)
            longest_interval = want.interval;
      end
      if (want.cavity == CAV_HI || want.cavity == CAV_LO)
         saturated_hits++;
   endfunction

   // sample driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_cavity(on_bus);
            samples_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
               send_gap = $urandom_range(1, 3);
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               on_bus = pending_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {6'd0, on_bus.value};
               req_tuser <= on_bus.restart;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_cavity_result(rsp_tdata);
         if (rsp_blocked) begin
            rsp_tready <= 1'b0;
         end else begin
            if (take_gap == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
               take_gap = $urandom_range(1, 3);
            if (take_gap > 0) begin
               take_gap--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // long receiver hold-off while the sender keeps offering, fills the block
   initial begin
      while (!(samples_taken >= 150 && pending_q.size() > 60))
         @(posedge clock);
      rsp_blocked <= 1'b1;
      repeat (48) @(posedge clock);
      rsp_blocked <= 1'b0;
   end

   initial begin
      #40_000_000;
      $display("%0t: timeout, %0d results still pending", $time, cavity_result_q.size());
      $display("TB_ERROR");
      $finish;
   end

   task automatic push_sample(int v, bit r);
      voltage_sample_type s;
      s.value = v[SAMPLE_W-1:0];
      s.restart = r;
      pending_q.insert(pending_q.size(), s);
   endtask

   task automatic wait_drained();
      while (pending_q.size() != 0 || req_tvalid || cavity_result_q.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_INCEPTION: uz_cfg = val[THRESH_W-1:0];
         CSR_RESIDUAL: up_cfg = val[THRESH_W-1:0];
         CSR_OFFSET: u0_cfg = val;
         default: ;
      endcase
   endtask

   task automatic load_settings(int uz_v, int up_v, int u0_v);
      wait_drained();
      write_reg(CSR_INCEPTION, uz_v[CSR_DATA_W-1:0]);
      write_reg(CSR_RESIDUAL, up_v[CSR_DATA_W-1:0]);
      write_reg(CSR_OFFSET, u0_v[CSR_DATA_W-1:0]);
      settings_used++;
   endtask

   // triangle-shaped supply cycle locked to the phase counter, plus jitter
   task automatic add_waveform(int len, int amp, int jitter, bit fresh);
      int p;
      longint v;
      voltage_sample_type s;
      for (int k = 0; k < len; k++) begin
         p = k % PERIOD;
         if (p < HALF / 2)
            v = longint'(amp) * p / (HALF / 2);
         else if (p < 3 * HALF / 2)
            v = longint'(amp) * (HALF - p) / (HALF / 2);
         else
            v = longint'(amp) * (p - PERIOD) / (HALF / 2);
         v += longint'($urandom_range(0, 2 * jitter)) - jitter;
         s.value = clip_sample(v);
         s.restart = fresh && k == 0;
         pending_q.insert(pending_q.size(), s);
      end
   endtask

   task automatic add_noise(int len);
      int raw;
      voltage_sample_type s;
      for (int k = 0; k < len; k++) begin
         raw = $urandom_range(0, 262143);
         s.value = raw[SAMPLE_W-1:0];
         s.restart = $urandom_range(0, 9) == 0;
         pending_q.insert(pending_q.size(), s);
      end
   endtask

   initial begin
      int phase_items;
      int len;
      int uz_v;
      int up_v;
      int quiet_n;
      int n;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // defaults: first sample after reset, exact threshold, field extremes
      push_sample(0, 1'b0);
      push_sample(39322, 1'b0);
      push_sample(39321, 1'b0);
      push_sample(SAMPLE_HI, 1'b0);
      push_sample(SAMPLE_LO, 1'b0);
      push_sample(SAMPLE_HI, 1'b1);
      push_sample(SAMPLE_LO, 1'b1);
      push_sample(0, 1'b1);

      // residual above threshold pushes the cavity into saturation
      load_settings(0, SAMPLE_HI, SAMPLE_HI);
      push_sample(SAMPLE_HI, 1'b1);
      push_sample(SAMPLE_HI, 1'b0);
      push_sample(SAMPLE_HI, 1'b0);
      push_sample(0, 1'b0);

      // offset at its negative end gives the lowest cavity value
      load_settings(0, SAMPLE_HI, SAMPLE_LO);
      push_sample(SAMPLE_LO, 1'b1);
      push_sample(SAMPLE_LO, 1'b0);
      push_sample(0, 1'b0);
      push_sample(SAMPLE_LO, 1'b0);

      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: load_settings(0, 0, 0);
            1: load_settings(65536, 0, -65536);
            2: load_settings(SAMPLE_HI, SAMPLE_HI, SAMPLE_HI);
            3: load_settings(0, SAMPLE_HI, SAMPLE_LO);
            // bit 17 of the threshold write falls outside the register
            4: load_settings(131072 + 30000, 10000, int'($urandom_range(0, 131072)) - 65536);
            default: begin
               uz_v = $urandom_range(0, 65536);
               up_v = $urandom_range(0, uz_v);
               load_settings(uz_v, up_v, int'($urandom_range(0, 131072)) - 65536);
            end
         endcase
         idle_odds = (ph % 3 == 2) ? 0 : ((ph % 3 == 0) ? 3 : 8);
         phase_items = 0;
         while (phase_items < 150) begin
            if ($urandom_range(0, 99) < 85) begin
               len = $urandom_range(40, 200);
               add_waveform(len, $urandom_range(0, SAMPLE_HI), $urandom_range(0, 2000),
                            $urandom_range(0, 4) != 0);
            end else begin
               len = $urandom_range(5, 40);
               add_noise(len);
            end
            phase_items += len;
         end
      end

      // quiet stretch, then a late crossing with a long interval
      load_settings(40000, 0, 0);
      idle_odds = 0;
      quiet_n = 100;
      while ((quiet_n + 2) % PERIOD != 0)
         quiet_n++;
      push_sample(0, 1'b1);
      push_sample(40000, 1'b0);
      for (n = 0; n < quiet_n; n++) begin
         while (pending_q.size() >= 64)
            @(posedge clock);
         push_sample(40000, 1'b0);
      end
      push_sample(80000, 1'b0);
      push_sample(80000, 1'b0);
      push_sample(0, 1'b0);

      while (pending_q.size() != 0 || req_tvalid)
         @(posedge clock);
      for (n = 0; n < 1000 && cavity_result_q.size() != 0; n++)
         @(posedge clock);
      if (cavity_result_q.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected results never arrived", $time, cavity_result_q.size());
      end
      repeat (6) @(posedge clock);
      $display("covered %0d samples over %0d register settings, %0d results checked",
               samples_taken, settings_used, results_seen);
      $display("discharges %0d positive / %0d negative, %0d intervals (max %0d), %0d at rail",
               pos_discharges, neg_discharges, interval_hits, longest_interval, saturated_hits);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/pdcm_pkg.sv
rtl/pdcm_front.sv
rtl/pdcm_queue.sv
rtl/pdcm_back.sv
rtl/partial_discharge_cavity_model.sv
verif/partial_discharge_cavity_model_tb.sv
